### rtl/core/lss_pkg.sv
`timescale 1ns / 1ps
package lss_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int FUNC_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    F_PUSH   = 3'd0,
    F_POP    = 3'd1,
    F_SEARCH = 3'd2,
    F_PEEK   = 3'd3,
    F_LIST   = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_TOP,
    S_WALK
  } state_t;

  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         waddr;
    logic signed [DATA_W-1:0] wdata;
    logic                     re;
    logic [IDX_W-1:0]         raddr;
  } mem_req_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
    stat_t                    status;
    logic                     last;
  } res_t;

endpackage

### rtl/core/lifo_stack_with_search.sv
`timescale 1ns / 1ps
// Push, pop, peek, and search or list on an empty stack: the request passes through the emit
// or top-of-stack state, which loads the result into the output register once that is free;
// no new item is taken until then. Search walks the stored words from the top, one memory read
// a cycle; list emits one word a cycle while the output register is free.
// A synchronous active-low reset empties the stack and the output register; the word memory
// itself is not cleared, as only entries written by a push are ever read.
module lifo_stack_with_search
  import lss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [2:0]  in_tuser,   // func[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // data[31:0], position[36:32], zero fill[39:37]
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast
);

  mem_req_t                 mem_req;
  logic signed [DATA_W-1:0] rdata;
  res_t                     res;
  logic                     out_free;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_data_r;
  logic [POS_W-1:0]         out_pos_r;
  stat_t                    out_stat_r;
  logic                     out_last_r;

  assign out_free = !out_valid_r || out_tready;

  lss_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  lss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .func     (in_tuser),
    .value    (in_tdata),
    .out_free (out_free),
    .mem_req  (mem_req),
    .rdata    (rdata),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data_r <= res.data;
      out_pos_r  <= res.position;
      out_stat_r <= res.status;
      out_last_r <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_pos_r, out_data_r};
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

  a_res_fits: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> out_free)
    else $error("result produced while the output register is occupied");

  a_unused_func: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser != F_PUSH && in_tuser != F_POP &&
     in_tuser != F_SEARCH && in_tuser != F_PEEK && in_tuser != F_LIST)
    |=> (in_tready && !res.valid))
    else $error("unused operation code left the controller busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata[31:0] == 32'd0 && out_tlast))
    else $error("error result carries data or is not final");

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == F_LIST) |=> !in_tready)
    else $error("list request did not occupy the controller");

endmodule

### rtl/core/lss_mem.sv
`timescale 1ns / 1ps
module lss_mem
  import lss_pkg::*;
(
  input  logic                     clk,
  input  mem_req_t                 req,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_q[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem_q[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/lss_ctrl.sv
`timescale 1ns / 1ps
module lss_ctrl
  import lss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [FUNC_W-1:0]        func,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     out_free,
  output mem_req_t                 mem_req,
  input  logic signed [DATA_W-1:0] rdata,
  output res_t                     res
);

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic [IDX_W-1:0]         ptr_r, ptr_nxt;
  logic [CNT_W-1:0]         pos_r, pos_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic                     list_r, list_nxt;
  stat_t                    hstat_r, hstat_nxt;
  logic [CNT_W-1:0]         hpos_r, hpos_nxt;

  logic             accept;
  logic             empty;
  logic             full;
  logic             done;
  logic             hit;
  logic [IDX_W-1:0] top_idx;

  assign accept  = in_valid && in_ready;
  assign empty   = (fill_r == '0);
  assign full    = (fill_r == CNT_W'(DEPTH));
  assign done    = (pos_r == fill_r);
  assign hit     = (rdata == key_r);
  assign top_idx = IDX_W'(fill_r - CNT_W'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (func)
            F_PUSH:            state_nxt = S_EMIT;
            F_POP, F_PEEK:     state_nxt = empty ? S_EMIT : S_TOP;
            F_SEARCH, F_LIST:  state_nxt = empty ? S_EMIT : S_WALK;
            default:           state_nxt = S_IDLE;
          endcase
        end
      end
      S_EMIT, S_TOP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        if (list_r) begin
          if (out_free && done) begin
            state_nxt = S_IDLE;
          end
        end else if (hit || done) begin
          state_nxt = S_EMIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == S_IDLE);
    mem_req       = '0;
    mem_req.wdata = value;
    res           = '0;
    res.status    = ST_OK;
    res.last      = 1'b1;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    list_nxt      = list_r;
    hstat_nxt     = hstat_r;
    hpos_nxt      = hpos_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          hpos_nxt  = '0;
          hstat_nxt = ST_EMPTY;
          key_nxt   = value;
          case (func)
            F_PUSH: begin
              if (full) begin
                hstat_nxt = ST_FULL;
              end else begin
                hstat_nxt     = ST_OK;
                mem_req.we    = 1'b1;
                mem_req.waddr = IDX_W'(fill_r);
                fill_nxt      = fill_r + CNT_W'(1);
              end
            end
            F_POP, F_PEEK: begin
              if (!empty) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = top_idx;
                if (func == F_POP) begin
                  fill_nxt = fill_r - CNT_W'(1);
                end
              end
            end
            F_SEARCH, F_LIST: begin
              if (!empty) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = top_idx;
                ptr_nxt       = top_idx;
                pos_nxt       = CNT_W'(1);
                list_nxt      = (func == F_LIST);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          res.valid    = 1'b1;
          res.position = POS_W'(hpos_r);
          res.status   = hstat_r;
        end
      end
      S_TOP: begin
        if (out_free) begin
          res.valid = 1'b1;
          res.data  = rdata;
        end
      end
      S_WALK: begin
        if (list_r) begin
          if (out_free) begin
            res.valid    = 1'b1;
            res.data     = rdata;
            res.position = POS_W'(pos_r);
            res.last     = done;
            if (!done) begin
              mem_req.re    = 1'b1;
              mem_req.raddr = ptr_r - IDX_W'(1);
              ptr_nxt       = ptr_r - IDX_W'(1);
              pos_nxt       = pos_r + CNT_W'(1);
            end
          end
        end else if (hit) begin
          hstat_nxt = ST_OK;
          hpos_nxt  = pos_r;
        end else if (done) begin
          hstat_nxt = ST_NOTFOUND;
          hpos_nxt  = '0;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ptr_r - IDX_W'(1);
          ptr_nxt       = ptr_r - IDX_W'(1);
          pos_nxt       = pos_r + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    pos_r   <= pos_nxt;
    key_r   <= key_nxt;
    list_r  <= list_nxt;
    hstat_r <= hstat_nxt;
    hpos_r  <= hpos_nxt;
  end

endmodule

### tb/sv/lifo_stack_with_search_tb.sv
`timescale 1ns / 1ps
module lifo_stack_with_search_tb;
  import lss_pkg::*;

  localparam int IDLE_LIMIT    = 1500;
  localparam int RANDOM_ITEMS  = 400;
  localparam int DRAIN_CYCLES  = 40;
  localparam int REPORT_LIMIT  = 10;

  typedef struct {
    logic [DATA_W-1:0] data;
    logic [POS_W-1:0]  position;
    stat_t             status;
    logic              last;
  } stack_result_t;

  typedef enum int {
    MIX_BALANCED,
    MIX_FILL,
    MIX_DRAIN
  } traffic_mix_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  logic [DATA_W-1:0] stack_words [DEPTH];
  int unsigned       stack_fill = 0;
  stack_result_t     pending_results [$];
  int                mismatches = 0;
  int                idle_cycles = 0;
  int                ready_hold = 0;
  bit                steady_flow = 1'b0;

  lifo_stack_with_search dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (steady_flow) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        return 32'h8000_0000;
      end
      1: begin
        return 32'h7fff_ffff;
      end
      2, 3, 4: begin
        return DATA_W'($urandom_range(0, 7));
      end
      5: begin
        return -DATA_W'($urandom_range(1, 4));
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  function automatic void expect_result(logic [DATA_W-1:0] data, logic [POS_W-1:0] position,
                                        stat_t status, logic last);
    stack_result_t r;
    r.data     = data;
    r.position = position;
    r.status   = status;
    r.last     = last;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_stack_op(logic [2:0] op, logic [DATA_W-1:0] word);
    int unsigned i;
    bit          hit;
    hit = 1'b0;
    case (op)
      F_PUSH: begin
        if (stack_fill >= DEPTH) begin
          expect_result('0, '0, ST_FULL, 1'b1);
        end else begin
          stack_words[stack_fill] = word;
          stack_fill++;
          expect_result('0, '0, ST_OK, 1'b1);
        end
      end
      F_POP: begin
        if (stack_fill == 0) begin
          expect_result('0, '0, ST_EMPTY, 1'b1);
        end else begin
          stack_fill--;
          expect_result(stack_words[stack_fill], '0, ST_OK, 1'b1);
        end
      end
      F_SEARCH: begin
        if (stack_fill == 0) begin
          expect_result('0, '0, ST_EMPTY, 1'b1);
        end else begin
          for (i = 0; i < stack_fill && !hit; i++) begin
            if (stack_words[stack_fill - 1 - i] == word) begin
              expect_result('0, POS_W'(i + 1), ST_OK, 1'b1);
              hit = 1'b1;
            end
          end
          if (!hit) begin
            expect_result('0, '0, ST_NOTFOUND, 1'b1);
          end
        end
      end
      F_PEEK: begin
        if (stack_fill == 0) begin
          expect_result('0, '0, ST_EMPTY, 1'b1);
        end else begin
          expect_result(stack_words[stack_fill - 1], '0, ST_OK, 1'b1);
        end
      end
      F_LIST: begin
        if (stack_fill == 0) begin
          expect_result('0, '0, ST_EMPTY, 1'b1);
        end else begin
          for (i = 0; i < stack_fill; i++) begin
            expect_result(stack_words[stack_fill - 1 - i], POS_W'(i + 1), ST_OK,
                          (i + 1 == stack_fill));
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [DATA_W-1:0] word);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      in_tuser  <= 3'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_stack_op(op, word);
  endtask

  function automatic logic [DATA_W-1:0] pick_search_key();
    if (stack_fill > 0 && $urandom_range(0, 9) < 6) begin
      return stack_words[$urandom_range(0, stack_fill - 1)];
    end
    return pick_word();
  endfunction

  task automatic test_empty_requests();
    send_item(F_POP, $urandom);
    send_item(F_PEEK, $urandom);
    send_item(F_SEARCH, 32'h0);
    send_item(F_LIST, $urandom);
    for (int c = F_LIST + 1; c < 8; c++) begin
      send_item(3'(c), $urandom);
    end
  endtask

  task automatic test_fill_and_overflow();
    logic [DATA_W-1:0] fill_words [DEPTH];
    fill_words[0] = 32'h8000_0000;
    fill_words[1] = 32'h7fff_ffff;
    fill_words[2] = 32'h0000_0005;
    fill_words[3] = 32'hffff_ffff;
    fill_words[4] = 32'h0000_0000;
    fill_words[5] = 32'h5555_5555;
    fill_words[6] = 32'haaaa_aaaa;
    fill_words[7] = 32'h0000_0005;
    for (int i = 8; i < DEPTH - 1; i++) begin
      fill_words[i] = 32'h1000_0000 | DATA_W'(i);
    end
    fill_words[DEPTH - 1] = 32'h0000_0001;
    for (int i = 0; i < DEPTH; i++) begin
      send_item(F_PUSH, fill_words[i]);
    end
    send_item(F_PUSH, 32'h1234_5678);
    send_item(F_LIST, $urandom);
    send_item(F_PEEK, $urandom);
  endtask

  task automatic test_search_positions();
    send_item(F_SEARCH, 32'h0000_0001);
    send_item(F_SEARCH, 32'h8000_0000);
    send_item(F_SEARCH, 32'h0000_0005);
    send_item(F_SEARCH, 32'h1234_5678);
    send_item(F_POP, $urandom);
  endtask

  task automatic test_random_traffic();
    traffic_mix_t mix;
    int           sent;
    int           r;
    int           push_share;
    int           pop_share;
    logic [2:0]   op;
    logic [DATA_W-1:0] word;
    sent = 0;
    mix  = MIX_DRAIN;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 40 == 0) begin
        steady_flow = ($urandom_range(0, 3) == 0);
        if (sent != 0) begin
          mix = traffic_mix_t'($urandom_range(0, 2));
        end
      end
      case (mix)
        MIX_FILL: begin
          push_share = 60;
          pop_share  = 10;
        end
        MIX_DRAIN: begin
          push_share = 10;
          pop_share  = 55;
        end
        default: begin
          push_share = 33;
          pop_share  = 27;
        end
      endcase
      r = $urandom_range(0, 99);
      if (r < 4) begin
        op = 3'($urandom_range(F_LIST + 1, 7));
      end else if (r < push_share) begin
        op = F_PUSH;
      end else if (r < push_share + pop_share) begin
        op = F_POP;
      end else if (r < push_share + pop_share + 15) begin
        op = F_SEARCH;
      end else if (r < push_share + pop_share + 27) begin
        op = F_PEEK;
      end else begin
        op = F_LIST;
      end
      case (op)
        F_PUSH: begin
          word = pick_word();
        end
        F_SEARCH: begin
          word = pick_search_key();
        end
        default: begin
          word = $urandom;
        end
      endcase
      send_item(op, word);
      if (op <= F_LIST) begin
        sent++;
      end
    end
    steady_flow = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input stack_result_t want);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display({"%0t: %s: expected data=%h pos=%0d status=%s last=%b, ",
                "got data=%h pos=%0d status=%0d last=%b"},
               $realtime, what, want.data, want.position, want.status.name(), want.last,
               out_tdata[31:0], out_tdata[36:32], out_tuser, out_tlast);
    end
  endtask

  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        want = '{data: '0, position: '0, status: ST_OK, last: 1'b0};
        report_mismatch("unexpected item", want);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.data || out_tdata[36:32] !== want.position ||
            out_tuser !== want.status || out_tlast !== want.last) begin
          report_mismatch("result mismatch", want);
        end
      end
    end
  end

  always @(negedge clk) begin
    logic next_ready;
    int   r;
    next_ready = 1'b1;
    if (ready_hold > 0) begin
      ready_hold--;
      next_ready = 1'b0;
    end else if (!steady_flow) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        ready_hold = $urandom_range(0, 2);
        next_ready = 1'b0;
      end else if (r < 23) begin
        ready_hold = $urandom_range(10, 60);
        next_ready = 1'b0;
      end
    end
    out_tready <= next_ready;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("lifo_stack_with_search_tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_requests();
    test_fill_and_overflow();
    test_search_positions();
    test_random_traffic();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("lifo_stack_with_search_tb: done, clean");
    end else begin
      $display("lifo_stack_with_search_tb: done, errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/lss_pkg.sv
rtl/core/lss_mem.sv
rtl/core/lss_ctrl.sv
rtl/core/lifo_stack_with_search.sv
tb/sv/lifo_stack_with_search_tb.sv
